FILE: hw/rtl/pirm_pkg.sv
`timescale 1ns / 1ps

package pirm_pkg;

   localparam int unsigned CAPACITY_DEF = 1024;
   localparam int unsigned POS_W        = 11;
   localparam int unsigned VAL_W        = 32;
   localparam int unsigned STATUS_W     = 2;

   // returned for every result that is not a range minimum
   localparam logic signed [VAL_W-1:0] EMPTY_SENTINEL = 32'sd2000000000;

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_QUERY  = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_RESULT   = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_PUT,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      status_type              status;
      logic signed [VAL_W-1:0] min_value;
   } result_type;

endpackage

FILE: hw/rtl/pirm_req_if.sv
`timescale 1ns / 1ps

interface pirm_req_if;
   import pirm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic [POS_W-1:0]        position;
   logic [POS_W-1:0]        range_end;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, cmd, position, range_end, value, input ready);
   modport sink (input valid, cmd, position, range_end, value, output ready);
endinterface

FILE: hw/rtl/pirm_rsp_if.sv
`timescale 1ns / 1ps

interface pirm_rsp_if;
   import pirm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic signed [VAL_W-1:0] min_value;

   modport source (output valid, status, min_value, input ready);
   modport sink (input valid, status, min_value, output ready);
endinterface

FILE: hw/rtl/pirm_ram.sv
`timescale 1ns / 1ps

module pirm_ram #(
   parameter int unsigned WIDTH = pirm_pkg::VAL_W,
   parameter int unsigned DEPTH = pirm_pkg::CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: hw/rtl/pirm_ctrl.sv
`timescale 1ns / 1ps

module pirm_ctrl #(
   parameter int unsigned CAPACITY = pirm_pkg::CAPACITY_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   pirm_req_if.sink             req_ch,
   output logic                 res_valid,
   input  logic                 res_ready,
   output pirm_pkg::result_type res
);
   import pirm_pkg::*;

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

   state_type state_ff, state_in;

   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           rem_ff, rem_in;
   logic                    pend_ff, pend_in;
   logic                    have_ff, have_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [AW-1:0]           wr_addr_ff, wr_addr_in;
   logic [AW-1:0]           put_addr_ff, put_addr_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic signed [VAL_W-1:0] min_ff, min_in;
   result_type              res_ff, res_in;

   logic                    mem_wr_en;
   logic [AW-1:0]           mem_wr_addr;
   logic [VAL_W-1:0]        mem_wr_data;
   logic                    mem_rd_en;
   logic signed [VAL_W-1:0] mem_rd_data;

   logic          accept;
   logic          is_query;
   logic          full;
   logic          empty;
   logic [XW-1:0] pos_x, end_x, n_x, ins_x, first_x, last_x;

   pirm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data)
   );

   // command decode, clamping of positions against the element count
   always_comb begin
      pos_x    = XW'(req_ch.position);
      end_x    = XW'(req_ch.range_end);
      n_x      = XW'(count_ff);
      is_query = (req_ch.cmd == CMD_QUERY);
      full     = (count_ff == CW'(CAPACITY));
      ins_x    = (pos_x > n_x) ? n_x : pos_x;
      first_x  = (pos_x == '0) ? XW'(1) : pos_x;
      last_x   = (end_x > n_x) ? n_x : end_x;
      empty    = (first_x > last_x);
      accept   = req_ch.valid && req_ch.ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (is_query) begin
                  state_in = empty ? S_DONE : S_SCAN;
               end else begin
                  state_in = full ? S_DONE : S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            if (rem_ff == '0 && !pend_ff) begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (rem_ff == '0 && !pend_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs and memory strobes
   always_comb begin
      req_ch.ready = 1'b0;
      res_valid    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wr_addr_ff;
      mem_wr_data  = mem_rd_data;
      mem_rd_en    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
         end
         S_SHIFT: begin
            mem_wr_en = pend_ff;
            mem_rd_en = (rem_ff != '0);
         end
         S_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = put_addr_ff;
            mem_wr_data = val_ff;
         end
         S_SCAN: begin
            mem_rd_en = (rem_ff != '0);
         end
         S_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      count_in    = count_ff;
      rem_in      = rem_ff;
      pend_in     = 1'b0;
      have_in     = have_ff;
      addr_in     = addr_ff;
      wr_addr_in  = wr_addr_ff;
      put_addr_in = put_addr_ff;
      val_in      = val_ff;
      min_in      = min_ff;
      res_in      = res_ff;
      case (state_ff)
         S_IDLE: begin
            val_in  = req_ch.value;
            have_in = 1'b0;
            if (is_query) begin
               addr_in = AW'(first_x - XW'(1));
               rem_in  = CW'(last_x - first_x + XW'(1));
               res_in  = '{status: ST_EMPTY, min_value: EMPTY_SENTINEL};
            end else begin
               // walk down from the last element, moving each one up a slot
               addr_in     = AW'(n_x - XW'(1));
               rem_in      = CW'(n_x - ins_x);
               put_addr_in = AW'(ins_x);
               res_in      = '{status: ST_FULL, min_value: EMPTY_SENTINEL};
            end
         end
         S_SHIFT: begin
            if (rem_ff != '0) begin
               pend_in    = 1'b1;
               wr_addr_in = addr_ff + AW'(1);
               addr_in    = addr_ff - AW'(1);
               rem_in     = rem_ff - CW'(1);
            end
         end
         S_PUT: begin
            count_in = count_ff + CW'(1);
            res_in   = '{status: ST_INSERTED, min_value: EMPTY_SENTINEL};
         end
         S_SCAN: begin
            if (rem_ff != '0) begin
               pend_in = 1'b1;
               addr_in = addr_ff + AW'(1);
               rem_in  = rem_ff - CW'(1);
            end
            if (pend_ff) begin
               have_in = 1'b1;
               if (!have_ff || mem_rd_data < min_ff) begin
                  min_in = mem_rd_data;
               end
            end
            if (rem_ff == '0 && !pend_ff) begin
               res_in = '{status: ST_RESULT, min_value: min_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         have_ff  <= 1'b0;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         have_ff  <= have_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      wr_addr_ff  <= wr_addr_in;
      put_addr_ff <= put_addr_in;
      val_ff      <= val_in;
      min_ff      <= min_in;
      res_ff      <= res_in;
   end

   assign res = res_ff;

endmodule

FILE: hw/rtl/positional_insert_range_min_unit.sv
`timescale 1ns / 1ps

// Ordered store of up to CAPACITY signed 32-bit values held in one single-port-read,
// single-port-write RAM. An insert moves every element at or after the insert point
// up by one slot, one element per cycle, then writes the new value. The insert
// position is clamped to the count; an insert into a full store is dropped with the
// full status. A range-minimum query reads the clamped range one element per cycle;
// an empty range reads nothing and gets the empty status. One item is in work at a
// time; the result sits in an output register so the next request is taken while it
// waits to be read.
// No clearing pass after reset: only entries below the element count are ever read.

module positional_insert_range_min_unit #(
   parameter int unsigned CAPACITY = pirm_pkg::CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pirm_req_if.sink   req_ch,
   pirm_rsp_if.source rsp_ch
);
   import pirm_pkg::*;

   logic       res_valid;
   logic       res_ready;
   result_type res;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   pirm_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign res_ready = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.status    = out_ff.status;
   assign rsp_ch.min_value = out_ff.min_value;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import pirm_pkg::*;

   localparam int unsigned CAP        = CAPACITY_DEF;
   localparam int unsigned POS_MAX    = 1024;
   localparam int unsigned LONG_HOLD  = 500;
   localparam int unsigned DRAIN      = 20;
   localparam int unsigned CYCLE_CAP  = 7_000_000;

   typedef struct {
      cmd_type                 cmd;
      logic [POS_W-1:0]        first;
      logic [POS_W-1:0]        last;
      logic signed [VAL_W-1:0] value;
      bit                      typed;
      status_type              status;
      logic signed [VAL_W-1:0] min_value;
   } step_row_type;

   logic clock;
   logic reset;

   pirm_req_if req_bus ();
   pirm_rsp_if rsp_bus ();

   positional_insert_range_min_unit #(.CAPACITY(CAP)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // shadow copy of the ordered store
   logic signed [VAL_W-1:0] shadow [CAP];
   int unsigned             shadow_count;

   result_type   pending_results [$];
   step_row_type directed_steps [$];
   int unsigned  errors;
   int unsigned  results_seen;
   int unsigned  cycle_count;
   bit           calm;

   initial begin
      clock = 1'b0;
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Insert shifts the tail up by one; query takes the min over the clamped range.
   function automatic result_type shadow_step(input cmd_type c,
                                              input logic [POS_W-1:0] pos,
                                              input logic [POS_W-1:0] fin,
                                              input logic signed [VAL_W-1:0] v);
      result_type              r;
      int unsigned             at;
      int unsigned             lo;
      int unsigned             hi;
      int unsigned             k;
      logic signed [VAL_W-1:0] low;
      r.status    = ST_INSERTED;
      r.min_value = EMPTY_SENTINEL;
      if (c == CMD_INSERT) begin
         if (shadow_count >= CAP) begin
            r.status = ST_FULL;
         end else begin
            at = (32'(pos) > shadow_count) ? shadow_count : 32'(pos);
            for (k = shadow_count; k > at; k--)
               shadow[k] = shadow[k-1];
            shadow[at] = v;
            shadow_count++;
         end
      end else begin
         lo = (pos == '0) ? 32'd1 : 32'(pos);
         hi = (32'(fin) > shadow_count) ? shadow_count : 32'(fin);
         if (lo > hi) begin
            r.status = ST_EMPTY;
         end else begin
            low = shadow[lo-1];
            for (k = lo; k < hi; k++)
               if (shadow[k] < low)
                  low = shadow[k];
            r.status    = ST_RESULT;
            r.min_value = low;
         end
      end
      return r;
   endfunction

   function automatic logic signed [VAL_W-1:0] pick_value();
      logic signed [VAL_W-1:0] v;
      case ($urandom_range(0, 5))
         0: v = 32'sh8000_0000;
         1: v = 32'sh7fff_ffff;
         2: v = $signed($urandom_range(0, 40)) - 20;
         3: v = EMPTY_SENTINEL + $signed($urandom_range(0, 2)) - 1;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // One beat on the request side; the expectation is booked at acceptance.
   task automatic offer(input cmd_type c, input logic [POS_W-1:0] pos,
                        input logic [POS_W-1:0] fin, input logic signed [VAL_W-1:0] v,
                        input bit typed, input result_type fixed);
      result_type r;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= c;
      req_bus.position  <= pos;
      req_bus.range_end <= fin;
      req_bus.value     <= v;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      r = shadow_step(c, pos, fin, v);
      pending_results.push_back(typed ? fixed : r);
   endtask

   task automatic random_insert(input bit near_end);
      int unsigned at;
      case ($urandom_range(0, 9))
         0: at = POS_MAX;
         1: at = $urandom_range(shadow_count + 1, POS_MAX);
         default: begin
            if (near_end)
               at = $urandom_range(shadow_count, shadow_count > 8 ? shadow_count - 8 : 0);
            else
               at = $urandom_range(0, shadow_count);
         end
      endcase
      if (at > POS_MAX)
         at = POS_MAX;
      offer(CMD_INSERT, POS_W'(at), POS_W'($urandom_range(0, POS_MAX)), pick_value(),
            1'b0, '0);
   endtask

   task automatic random_query(input int unsigned widest);
      int unsigned first;
      int unsigned last;
      first = $urandom_range(0, shadow_count + 2);
      case ($urandom_range(0, 7))
         0: last = POS_MAX;
         1: last = (first == 0) ? 0 : first - 1;
         default: last = first + $urandom_range(0, widest);
      endcase
      if (first > POS_MAX)
         first = POS_MAX;
      if (last > POS_MAX)
         last = POS_MAX;
      offer(CMD_QUERY, POS_W'(first), POS_W'(last), $urandom, 1'b0, '0);
   endtask

   // result side: random stalls, one long hold-off to back up the request side
   initial begin : rsp_side
      int unsigned n;
      bit          held;
      held = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && results_seen >= 40) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            for (n = 0; n < LONG_HOLD; n++)
               @(posedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen <= results_seen + 1;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, status %0d min %0d", $time,
                     rsp_bus.status, rsp_bus.min_value);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_bus.status);
            end
            if (rsp_bus.min_value !== want.min_value) begin
               errors++;
               $display("%0t: min_value expected %0d actual %0d", $time,
                        want.min_value, rsp_bus.min_value);
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned  i;
      step_row_type row;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= CMD_INSERT;
      req_bus.position  <= '0;
      req_bus.range_end <= '0;
      req_bus.value     <= '0;
      errors       = 0;
      results_seen = 0;
      cycle_count  = 0;
      shadow_count = 0;
      calm         = 1'b0;

      // empty store, extremes, clamping, start after end, start of zero
      directed_steps.push_back('{CMD_QUERY, 11'd0, 11'd0, 32'sd0, 1'b1, ST_EMPTY,
                                 EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_QUERY, 11'd1, 11'd1024, -32'sd1, 1'b1, ST_EMPTY,
                                 EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_QUERY, 11'd1024, 11'd1024, 32'sd0, 1'b1, ST_EMPTY,
                                 EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_INSERT, 11'd0, 11'd0, 32'sh8000_0000, 1'b1,
                                 ST_INSERTED, EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_INSERT, 11'd1024, 11'd1024, 32'sh7fff_ffff, 1'b1,
                                 ST_INSERTED, EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_INSERT, 11'd1, 11'd2047, 32'sd0, 1'b1,
                                 ST_INSERTED, EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_QUERY, 11'd0, 11'd1024, 32'sd0, 1'b1, ST_RESULT,
                                 32'sh8000_0000});
      directed_steps.push_back('{CMD_QUERY, 11'd3, 11'd3, 32'sd0, 1'b1, ST_RESULT,
                                 32'sh7fff_ffff});
      directed_steps.push_back('{CMD_QUERY, 11'd2, 11'd3, 32'sd0, 1'b1, ST_RESULT,
                                 32'sd0});
      directed_steps.push_back('{CMD_QUERY, 11'd3, 11'd2, 32'sd0, 1'b1, ST_EMPTY,
                                 EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_QUERY, 11'd4, 11'd1024, 32'sd0, 1'b1, ST_EMPTY,
                                 EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_QUERY, 11'd2, 11'd0, 32'sd0, 1'b1, ST_EMPTY,
                                 EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_INSERT, 11'd3, 11'd0, -32'sd1, 1'b0, ST_INSERTED,
                                 EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_INSERT, 11'd0, 11'd1023, 32'sd5, 1'b0, ST_INSERTED,
                                 EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_QUERY, 11'd1, 11'd5, 32'sh5555_5555, 1'b0, ST_RESULT,
                                 EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_QUERY, 11'd0, 11'd1, 32'shaaaa_aaaa, 1'b0, ST_RESULT,
                                 EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_INSERT, 11'd2, 11'd0, 32'sh5555_5555, 1'b0,
                                 ST_INSERTED, EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_INSERT, 11'd4, 11'd0, 32'shaaaa_aaaa, 1'b0,
                                 ST_INSERTED, EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_QUERY, 11'd1023, 11'd1024, 32'sd0, 1'b1, ST_EMPTY,
                                 EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_QUERY, 11'd5, 11'd1023, 32'sd0, 1'b0, ST_RESULT,
                                 EMPTY_SENTINEL});
      directed_steps.push_back('{CMD_QUERY, 11'd2, 11'd6, 32'sd0, 1'b0, ST_RESULT,
                                 EMPTY_SENTINEL});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[j]) begin
         row = directed_steps[j];
         offer(row.cmd, row.first, row.last, row.value, row.typed,
               result_type'{row.status, row.min_value});
      end

      // small store: mixed inserts and queries
      for (i = 0; i < 250; i++) begin
         if (shadow_count < 160 && $urandom_range(0, 1) == 0)
            random_insert(1'b0);
         else
            random_query(24);
      end

      // fill to capacity, mostly near the tail to keep shifts short
      while (shadow_count < CAP) begin
         if ($urandom_range(0, 9) == 0)
            random_query(16);
         else
            random_insert($urandom_range(0, 59) != 0);
      end

      // full store: dropped inserts and queries, quiet at the end
      for (i = 0; i < 250; i++) begin
         if (i == 130)
            calm = 1'b1;
         if ($urandom_range(0, 4) < 2)
            random_insert(1'b0);
         else if ($urandom_range(0, 24) == 0)
            offer(CMD_QUERY, POS_W'($urandom_range(0, 3)),
                  POS_W'($urandom_range(1000, POS_MAX)), $urandom, 1'b0, '0);
         else
            random_query(40);
      end

      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/pirm_pkg.sv
hw/rtl/pirm_req_if.sv
hw/rtl/pirm_rsp_if.sv
hw/rtl/pirm_ram.sv
hw/rtl/pirm_ctrl.sv
hw/rtl/positional_insert_range_min_unit.sv
sim/tb.sv
